### src/cbdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// City-block distance transform package
// Shared constants, item types, controller types and the size clamp.
// ----------------------------------------------------------------------------
package cbdt_pkg;

   // Largest image side and the widths that follow from it.
   localparam int MAX_SIDE    = 128;
   localparam int SIDE_BITS   = $clog2(MAX_SIDE);
   localparam int ADDR_BITS   = 2 * SIDE_BITS;
   localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
   // The forward pass can leave values up to MAX_SIDE before the backward pass.
   localparam int STORE_BITS  = $clog2(MAX_SIDE + 1);
   localparam int SIZE_BITS   = $clog2(MAX_SIDE + 1);

   // Fixed field widths of the items and the register port.
   localparam int CFG_BITS       = 8;
   localparam int CSR_INDEX_BITS = 8;
   localparam int COORD_BITS     = 7;
   localparam int DIST_BITS      = 7;

   // Reset value of both size registers.
   localparam logic [CFG_BITS-1:0] SIDE_RESET = 8'd128;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 8'd1;

   // Item commands.
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef struct packed {
      logic                  command;
      logic                  pixel;
      logic [COORD_BITS-1:0] read_row;
      logic [COORD_BITS-1:0] read_col;
   } req_item_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] distance;
      logic                 ready_res;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FWD_READ,
      ST_FWD_WRITE,
      ST_BWD_READ,
      ST_BWD_WRITE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic do_load;
      logic do_read;
      logic cfg_write;
      logic scan_update;
      logic scan_backward;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic load_last;
      logic scan_last;
   } ctrl_status_type;

   // A size of zero acts as one, a size above the maximum acts as the maximum.
   function automatic logic [SIZE_BITS-1:0] clamp_side(input logic [CFG_BITS-1:0] v);
      logic [SIZE_BITS-1:0] r;
      if (v == '0) begin
         r = SIZE_BITS'(1);
      end else if (v > CFG_BITS'(MAX_SIDE)) begin
         r = SIZE_BITS'(MAX_SIDE);
      end else begin
         r = SIZE_BITS'(v);
      end
      return r;
   endfunction

endpackage

### src/cbdt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module cbdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read ports.
   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

### src/cbdt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance transform controller
// Accepts items and register writes, and sequences the two raster passes.
// ----------------------------------------------------------------------------
module cbdt_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      command,
   input  logic                      csr_valid,
   input  cbdt_pkg::ctrl_status_type status,
   output logic                      busy,
   output logic                      csr_ready,
   output cbdt_pkg::ctrl_cmd_type    cmd
);

   cbdt_pkg::state_type state_ff;
   cbdt_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbdt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state. Each pixel of a pass goes through a read state and then an update state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cbdt_pkg::ST_IDLE: begin
            if (start && command == cbdt_pkg::CMD_LOAD && status.load_last) begin
               state_in = cbdt_pkg::ST_FWD_READ;
            end
         end
         cbdt_pkg::ST_FWD_READ: begin
            state_in = cbdt_pkg::ST_FWD_WRITE;
         end
         cbdt_pkg::ST_FWD_WRITE: begin
            state_in = status.scan_last ? cbdt_pkg::ST_BWD_READ : cbdt_pkg::ST_FWD_READ;
         end
         cbdt_pkg::ST_BWD_READ: begin
            state_in = cbdt_pkg::ST_BWD_WRITE;
         end
         cbdt_pkg::ST_BWD_WRITE: begin
            state_in = status.scan_last ? cbdt_pkg::ST_IDLE : cbdt_pkg::ST_BWD_READ;
         end
         default: begin
            state_in = cbdt_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      busy              = 1'b1;
      csr_ready         = 1'b0;
      cmd.do_load       = 1'b0;
      cmd.do_read       = 1'b0;
      cmd.cfg_write     = 1'b0;
      cmd.scan_update   = 1'b0;
      cmd.scan_backward = 1'b0;
      case (state_ff)
         cbdt_pkg::ST_IDLE: begin
            busy          = 1'b0;
            csr_ready     = 1'b1;
            cmd.cfg_write = csr_valid;
            cmd.do_load   = start && command == cbdt_pkg::CMD_LOAD;
            cmd.do_read   = start && command == cbdt_pkg::CMD_READ;
         end
         cbdt_pkg::ST_FWD_READ: begin
            cmd.scan_backward = 1'b0;
         end
         cbdt_pkg::ST_FWD_WRITE: begin
            cmd.scan_update = 1'b1;
         end
         cbdt_pkg::ST_BWD_READ: begin
            cmd.scan_backward = 1'b1;
         end
         cbdt_pkg::ST_BWD_WRITE: begin
            cmd.scan_update   = 1'b1;
            cmd.scan_backward = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

### src/cbdt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance transform datapath
// Size registers, load and scan counters, the distance store, the pass
// arithmetic and the read response pipeline.
// ----------------------------------------------------------------------------
module cbdt_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cbdt_pkg::ctrl_cmd_type                 cmd,
   output cbdt_pkg::ctrl_status_type              status,
   input  cbdt_pkg::req_item_type                 req_item,
   input  logic [cbdt_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [cbdt_pkg::CFG_BITS-1:0]          csr_data,
   output logic                                   rsp_strobe,
   output cbdt_pkg::rsp_item_type                 rsp_item
);

   localparam int SB = cbdt_pkg::SIDE_BITS;
   localparam int ZB = cbdt_pkg::SIZE_BITS;
   localparam int DB = cbdt_pkg::STORE_BITS;
   localparam int AB = cbdt_pkg::ADDR_BITS;

   // Registers and next values.
   logic [cbdt_pkg::CFG_BITS-1:0] width_ff, width_in;
   logic [cbdt_pkg::CFG_BITS-1:0] height_ff, height_in;
   logic [SB-1:0]                 load_row_ff, load_row_in;
   logic [SB-1:0]                 load_col_ff, load_col_in;
   logic                          done_ff, done_in;
   logic [SB-1:0]                 scan_row_ff, scan_row_in;
   logic [SB-1:0]                 scan_col_ff, scan_col_in;
   logic [DB-1:0]                 prev_ff, prev_in;
   logic                          rd_valid_ff, rd_valid_in;
   logic                          rd_hit_ff, rd_hit_in;
   logic                          rd_done_ff, rd_done_in;
   logic                          rsp_strobe_ff, rsp_strobe_in;
   cbdt_pkg::rsp_item_type        rsp_item_ff, rsp_item_in;

   // Effective sizes and their last positions.
   logic [ZB-1:0] w_eff, h_eff;
   logic [SB-1:0] w_last, h_last;

   // Store ports.
   logic          wr_en;
   logic [AB-1:0] wr_addr;
   logic [DB-1:0] wr_data;
   logic [AB-1:0] rd_addr_a, rd_addr_b;
   logic [DB-1:0] rd_data_a, rd_data_b;

   // Scan helpers.
   logic          load_col_end, load_row_end;
   logic          scan_col_end, scan_row_end;
   logic [SB-1:0] nb_row;
   logic          nb_valid, prev_valid;
   logic [DB-1:0] nb_val, prev_val, fwd_min, fwd_val;
   logic [DB:0]   bwd_nb, bwd_prev, bwd_min;
   logic [DB-1:0] scan_val;
   logic          read_in_range;

   assign w_eff  = cbdt_pkg::clamp_side(width_ff);
   assign h_eff  = cbdt_pkg::clamp_side(height_ff);
   assign w_last = SB'(w_eff - ZB'(1));
   assign h_last = SB'(h_eff - ZB'(1));

   // Load position and pass position end tests.
   assign load_col_end = load_col_ff == w_last;
   assign load_row_end = load_row_ff == h_last;
   assign scan_col_end = cmd.scan_backward ? (scan_col_ff == '0) : (scan_col_ff == w_last);
   assign scan_row_end = cmd.scan_backward ? (scan_row_ff == '0) : (scan_row_ff == h_last);

   assign status.load_last = load_col_end && load_row_end;
   assign status.scan_last = scan_col_end && scan_row_end;

   // The vertical neighbor is the row above going forward and below going back.
   assign nb_row     = cmd.scan_backward ? (scan_row_ff + SB'(1)) : (scan_row_ff - SB'(1));
   assign nb_valid   = cmd.scan_backward ? (scan_row_ff != h_last) : (scan_row_ff != '0);
   assign prev_valid = cmd.scan_backward ? (scan_col_ff != w_last) : (scan_col_ff != '0);
   assign nb_val     = nb_valid ? rd_data_b : '0;
   assign prev_val   = prev_valid ? prev_ff : '0;

   // Forward pass: a zero pixel stays zero, else one more than the smaller of the upper and left values.
   assign fwd_min = (nb_val < prev_val) ? nb_val : prev_val;
   assign fwd_val = (rd_data_a == '0) ? '0 : (fwd_min + DB'(1));

   // Backward pass: the smallest of the value and its lower and right values plus one.
   always_comb begin
      bwd_nb   = {1'b0, nb_val} + (DB + 1)'(1);
      bwd_prev = {1'b0, prev_val} + (DB + 1)'(1);
      bwd_min  = {1'b0, rd_data_a};
      if (bwd_nb < bwd_min) begin
         bwd_min = bwd_nb;
      end
      if (bwd_prev < bwd_min) begin
         bwd_min = bwd_prev;
      end
   end

   assign scan_val = cmd.scan_backward ?
                     ((rd_data_a == '0) ? '0 : bwd_min[DB-1:0]) : fwd_val;

   assign read_in_range = (ZB'(req_item.read_row) < h_eff) && (ZB'(req_item.read_col) < w_eff);

   // Store port selection.
   always_comb begin
      rd_addr_a = cmd.do_read ? {req_item.read_row, req_item.read_col}
                              : {scan_row_ff, scan_col_ff};
      rd_addr_b = {nb_row, scan_col_ff};
      wr_en     = cmd.do_load || cmd.scan_update;
      if (cmd.do_load) begin
         wr_addr = {load_row_ff, load_col_ff};
         wr_data = DB'(req_item.pixel);
      end else begin
         wr_addr = {scan_row_ff, scan_col_ff};
         wr_data = scan_val;
      end
   end

   cbdt_ram #(
      .WIDTH (DB),
      .DEPTH (cbdt_pkg::STORE_DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // Size registers, load position and the image-done flag.
   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      load_row_in = load_row_ff;
      load_col_in = load_col_ff;
      done_in     = done_ff;
      if (cmd.cfg_write) begin
         case (csr_index)
            cbdt_pkg::REG_IMAGE_WIDTH: begin
               width_in    = csr_data;
               load_row_in = '0;
               load_col_in = '0;
               done_in     = 1'b0;
            end
            cbdt_pkg::REG_IMAGE_HEIGHT: begin
               height_in   = csr_data;
               load_row_in = '0;
               load_col_in = '0;
               done_in     = 1'b0;
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
      if (cmd.do_load) begin
         // The first pixel of an image drops the previous result.
         if (load_row_ff == '0 && load_col_ff == '0) begin
            done_in = 1'b0;
         end
         if (load_col_end) begin
            load_col_in = '0;
            load_row_in = load_row_end ? '0 : (load_row_ff + SB'(1));
         end else begin
            load_col_in = load_col_ff + SB'(1);
         end
      end
      if (cmd.scan_update && cmd.scan_backward && status.scan_last) begin
         done_in = 1'b1;
      end
   end

   // Pass position and the previous pixel's new value.
   always_comb begin
      scan_row_in = scan_row_ff;
      scan_col_in = scan_col_ff;
      prev_in     = prev_ff;
      if (cmd.do_load && status.load_last) begin
         scan_row_in = '0;
         scan_col_in = '0;
      end
      if (cmd.scan_update) begin
         prev_in = scan_val;
         if (!cmd.scan_backward) begin
            if (status.scan_last) begin
               scan_row_in = h_last;
               scan_col_in = w_last;
            end else if (scan_col_end) begin
               scan_col_in = '0;
               scan_row_in = scan_row_ff + SB'(1);
            end else begin
               scan_col_in = scan_col_ff + SB'(1);
            end
         end else begin
            if (scan_col_end) begin
               scan_col_in = w_last;
               scan_row_in = scan_row_ff - SB'(1);
            end else begin
               scan_col_in = scan_col_ff - SB'(1);
            end
         end
      end
   end

   // Read response: store data arrives in the cycle after the read item.
   always_comb begin
      rd_valid_in           = cmd.do_read;
      rd_hit_in             = done_ff && read_in_range;
      rd_done_in            = done_ff;
      rsp_strobe_in         = rd_valid_ff;
      rsp_item_in.distance  = rd_hit_ff ? rd_data_a[cbdt_pkg::DIST_BITS-1:0] : '0;
      rsp_item_in.ready_res = rd_done_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= cbdt_pkg::SIDE_RESET;
         height_ff     <= cbdt_pkg::SIDE_RESET;
         load_row_ff   <= '0;
         load_col_ff   <= '0;
         done_ff       <= 1'b0;
         scan_row_ff   <= '0;
         scan_col_ff   <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         load_row_ff   <= load_row_in;
         load_col_ff   <= load_col_in;
         done_ff       <= done_in;
         scan_row_ff   <= scan_row_in;
         scan_col_ff   <= scan_col_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      prev_ff     <= prev_in;
      rd_hit_ff   <= rd_hit_in;
      rd_done_ff  <= rd_done_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

### src/city_block_distance_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// City-block distance transform
// Load item: busy stays low while pixels load, so pixels may arrive every cycle.
// Read item: one per cycle while busy is low; its strobe passes a valid register
// and then the strobe register. After the last pixel, busy stays high through
// both passes: each takes every pixel through a read state and an update state.
// Synchronous reset clears control state; the distance store is not cleared.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module city_block_distance_transform (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  cbdt_pkg::req_item_type              req_item,
   output logic                                rsp_strobe,
   output cbdt_pkg::rsp_item_type              rsp_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cbdt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cbdt_pkg::CFG_BITS-1:0]       csr_data
);

   cbdt_pkg::ctrl_cmd_type    cmd;
   cbdt_pkg::ctrl_status_type status;

   // Sequencing of items and passes.
   cbdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .command   (req_item.command),
      .csr_valid (csr_valid),
      .status    (status),
      .busy      (busy),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   // Store, counters and pass arithmetic.
   cbdt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_item   (req_item),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
